// ===== rtl/asc_pkg.sv =====
// Shared types, constants and tables for the analog stick conditioner.
package asc_pkg;

  localparam int COUNT_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = 5;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 15;
  localparam int THRESH           = 8192;
  localparam int QUARTER_TURN     = 5898240;   // 90 degrees, Q16
  localparam int ANGLE_BIAS       = 360 * 65536 + 32768;
  localparam int FULL_TURN        = 360;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS0   = 8'd0,
    REG_DEADZONE0 = 8'd1,
    REG_RADIUS1   = 8'd2,
    REG_DEADZONE1 = 8'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_e;

  // Command to the divide/square-root unit
  typedef struct packed {
    logic start;
    op_e  op;
  } ds_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_R,
    ST_CMP,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_FIN,
    ST_UPDATE,
    ST_ANGLE,
    ST_ANGLE_WAIT,
    ST_OUT
  } state_e;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/asc_divsqrt.sv =====
// Iterative restoring divider and bitwise square root sharing one compare-subtract.
module asc_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asc_pkg::ds_ctrl_t ctrl_i,
  input  logic [60:0]       num_i,
  input  logic [31:0]       den_i,
  output logic              done_o,
  output logic [30:0]       result_o
);
  import asc_pkg::*;

  localparam logic [4:0] DIV_STEPS  = 5'd31;
  localparam logic [4:0] SQRT_STEPS = 5'd16;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  op_e         op_q;
  logic [32:0] acc_q, acc_d;
  logic [30:0] nlo_q, nlo_d;
  logic [30:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;   // divisor, or the moving bit for square root
  logic [31:0] root_q, root_d;
  logic [32:0] cmp_a, cmp_b, diff;
  logic        ge;

  // shared compare-subtract
  always_comb begin
    if (op_q == OP_DIV) begin
      cmp_a = {acc_q[31:0], nlo_q[30]};
      cmp_b = {1'b0, den_q};
    end else begin
      cmp_a = acc_q;
      cmp_b = {1'b0, root_q + den_q};
    end
    ge   = cmp_a >= cmp_b;
    diff = cmp_a - cmp_b;
  end

  // one iteration
  always_comb begin
    acc_d  = acc_q;
    nlo_d  = nlo_q;
    quo_d  = quo_q;
    den_d  = den_q;
    root_d = root_q;
    if (op_q == OP_DIV) begin
      acc_d = ge ? diff : cmp_a;
      quo_d = {quo_q[29:0], ge};
      nlo_d = {nlo_q[29:0], 1'b0};
    end else begin
      acc_d  = ge ? diff : acc_q;
      root_d = ge ? ((root_q >> 1) + den_q) : (root_q >> 1);
      den_d  = den_q >> 2;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (ctrl_i.op == OP_DIV) ? DIV_STEPS : SQRT_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      op_q   <= ctrl_i.op;
      quo_q  <= '0;
      root_q <= '0;
      nlo_q  <= num_i[30:0];
      if (ctrl_i.op == OP_DIV) begin
        acc_q <= {3'b0, num_i[60:31]};
        den_q <= den_i;
      end else begin
        acc_q <= {2'b0, num_i[30:0]};
        den_q <= 32'h4000_0000;
      end
    end else if (busy_q) begin
      acc_q  <= acc_d;
      nlo_q  <= nlo_d;
      quo_q  <= quo_d;
      den_q  <= den_d;
      root_q <= root_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == OP_DIV) ? quo_q : root_q[30:0];

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divsqrt done held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> busy_q && !done_o) else $error("divsqrt did not start");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ctrl_i.start) else $error("divsqrt restarted while busy");
`endif

endmodule

// ===== rtl/asc_cordic.sv =====
// Iterative CORDIC vectoring unit giving the stick angle in whole degrees.
module asc_cordic #(
  parameter int CORDIC_STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  output logic               done_o,
  output logic [8:0]         angle_o
);
  import asc_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [27:0] Z_QUARTER = 28'(QUARTER_TURN);
  localparam logic signed [27:0] Z_BIAS    = 28'(ANGLE_BIAS);
  localparam logic [11:0] DEG_TURN = 12'(FULL_TURN);

  logic                    busy_q, fin_q, done_q, zero_q;
  logic [STEP_W-1:0]       i_q;
  logic signed [27:0]      x_q, y_q, z_q;
  logic signed [27:0]      xs, ys, x0, y0, z0;
  logic signed [27:0]      xsh, ysh, at;
  logic [27:0]             zt;
  logic [11:0]             deg;
  logic [8:0]              angle_q;

  // quadrant pre-rotation
  always_comb begin
    xs = {{4{px_i[15]}}, px_i, 8'b0};
    ys = -{{4{py_i[15]}}, py_i, 8'b0};
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (px_i[15]) begin
      if (!ys[27]) begin
        x0 = ys;
        y0 = -xs;
        z0 = Z_QUARTER;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -Z_QUARTER;
      end
    end
  end

  assign xsh = x_q >>> i_q;
  assign ysh = y_q >>> i_q;
  assign at  = $signed({6'b0, atan_q16(i_q)});

  // final rounding and wrap to 0..359
  assign zt  = 28'(z_q + Z_BIAS);
  assign deg = zt[27:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == LAST_STEP) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      zero_q <= (px_i == 16'sd0) && (py_i == 16'sd0);
    end else if (busy_q) begin
      if (y_q > 28'sd0) begin
        x_q <= x_q + ysh;
        y_q <= y_q - xsh;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ysh;
        y_q <= y_q + xsh;
        z_q <= z_q - at;
      end
    end
    if (fin_q) begin
      if (zero_q) begin
        angle_q <= '0;
      end else if (deg >= DEG_TURN) begin
        angle_q <= 9'(deg - DEG_TURN);
      end else begin
        angle_q <= deg[8:0];
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

`ifndef ASSERT_OFF
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> angle_o < 9'd360) else $error("angle out of range");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> done_o) else $error("cordic done missing");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("cordic restarted while busy");
`endif

endmodule

// ===== rtl/analog_stick_conditioner_unit.sv =====
// Top level of the analog stick conditioner: sequencer, registers and output stage.
//
// Input channel (in_valid_i/in_ready_o) takes one raw X/Y sample of stick 0 or 1.
// Output channel (out_valid_o/out_ready_i) gives one conditioned item per input:
// Q1.15 positions, angle in degrees, per-axis directions and frame counters.
// Config channel (cfg_valid_i/cfg_ready_o) writes radius and deadzone registers;
// it is always ready and must only be used while the block is idle.
// Each item walks a sequencer: the shared 16x16 multiplier forms the squares
// and the radius squared, then per axis a restoring division runs and, when
// the vector is clamped to the unit circle, a square root follows.
// A CORDIC_STEPS-iteration CORDIC unit then forms the angle.
// Most of the time per item goes to the divider iterations. in_ready_o is high
// only while idle, so a new item is taken only after the last one has left
// the sequencer.
// A finished item sits in the output register; the next item is accepted
// meanwhile, and its result waits for the register to drain if stalled.
// Reset clears direction state, counters, registers to their defaults
// (radius 32767, deadzone 0) and empties the output register.
module analog_stick_conditioner_unit #(
  parameter int COUNT_BITS   = asc_pkg::COUNT_BITS_DEF,
  parameter int CORDIC_STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            stick_select_i,
  input  logic signed [15:0]              raw_x_i,
  input  logic signed [15:0]              raw_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              pos_x_o,
  output logic signed [15:0]              pos_y_o,
  output logic [8:0]                      angle_deg_o,
  output logic [1:0]                      horiz_dir_o,
  output logic [1:0]                      vert_dir_o,
  output logic [15:0]                     frames_x_o,
  output logic [15:0]                     frames_y_o
);
  import asc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_e state_q, state_d;

  // config registers
  logic [14:0] radius_q [2];
  logic [14:0] dz_q [2];

  // per-stick state
  dir_e                  hdir_q [2];
  dir_e                  vdir_q [2];
  logic [COUNT_BITS-1:0] hcnt_q [2];
  logic [COUNT_BITS-1:0] vcnt_q [2];

  // item registers
  logic                s_q, axis_q, clamp_q;
  logic signed [15:0]  x_q, y_q;
  logic [14:0]         r_q, dzs_q;
  logic [30:0]         sqx_q, sqy_q;
  logic [31:0]         m2_q;
  logic [29:0]         rr_q;
  logic signed [15:0]  px_q, py_q;
  dir_e                hd_q, vd_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] opx_q, opy_q;
  logic [8:0]         oang_q;
  dir_e               ohd_q, ovd_q;
  logic [15:0]        ofx_q, ofy_q;

  // control from the output decoder
  ds_ctrl_t ds_ctrl;
  logic     cordic_start, load_out;

  logic        ds_done, cordic_done;
  logic [30:0] ds_result;
  logic [8:0]  cordic_angle;

  // magnitudes and shared multiplier
  logic [15:0] mag_x, mag_y, mag_a, mul_a;
  logic [31:0] prod;
  logic [14:0] r_sel;
  logic        neg_a;
  logic [30:0] sq_a;
  logic [60:0] ds_num;
  logic [31:0] ds_den;

  // axis finish
  logic [15:0]        q_a, qs_a;
  logic signed [15:0] p_a;
  dir_e               hd_new, vd_new;
  logic [COUNT_BITS-1:0] hcnt_new, vcnt_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign mag_x = x_q[15] ? 16'(-x_q) : x_q;
  assign mag_y = y_q[15] ? 16'(-y_q) : y_q;
  assign mag_a = axis_q ? mag_y : mag_x;
  assign neg_a = axis_q ? y_q[15] : x_q[15];
  assign sq_a  = axis_q ? sqy_q : sqx_q;
  assign r_sel = (radius_q[stick_select_i] == 15'd0) ? 15'd1 : radius_q[stick_select_i];

  always_comb begin
    case (state_q)
      ST_MUL_X: mul_a = mag_x;
      ST_MUL_Y: mul_a = mag_y;
      default:  mul_a = {1'b0, r_q};
    endcase
  end
  assign prod = mul_a * mul_a;

  // operands of the divide/square-root unit
  always_comb begin
    if (state_q == ST_SQRT) begin
      ds_num = {30'b0, ds_result};
      ds_den = m2_q;
    end else if (clamp_q) begin
      ds_num = {sq_a, 30'b0};
      ds_den = m2_q;
    end else begin
      ds_num = {30'b0, mag_a, 15'b0};
      ds_den = {17'b0, r_q};
    end
  end

  // saturate, apply deadzone, restore sign
  always_comb begin
    q_a  = ds_result[15:0];
    qs_a = (!neg_a && q_a == 16'h8000) ? 16'h7FFF : q_a;
    if (qs_a <= {1'b0, dzs_q}) begin
      p_a = '0;
    end else if (neg_a) begin
      p_a = 16'(-q_a);
    end else begin
      p_a = qs_a;
    end
  end

  // direction classification and counter update
  always_comb begin
    if (px_q <= -16'sd8192) begin
      hd_new = DIR_NEG;
    end else if (px_q >= 16'sd8192) begin
      hd_new = DIR_POS;
    end else begin
      hd_new = DIR_NONE;
    end
    if (py_q <= -16'sd8192) begin
      vd_new = DIR_NEG;
    end else if (py_q >= 16'sd8192) begin
      vd_new = DIR_POS;
    end else begin
      vd_new = DIR_NONE;
    end
    if (hd_new != hdir_q[s_q]) begin
      hcnt_new = '0;
    end else if (hcnt_q[s_q] != CNT_MAX) begin
      hcnt_new = hcnt_q[s_q] + 1'b1;
    end else begin
      hcnt_new = hcnt_q[s_q];
    end
    if (vd_new != vdir_q[s_q]) begin
      vcnt_new = '0;
    end else if (vcnt_q[s_q] != CNT_MAX) begin
      vcnt_new = vcnt_q[s_q] + 1'b1;
    end else begin
      vcnt_new = vcnt_q[s_q];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_MUL_X;
      ST_MUL_X:      state_d = ST_MUL_Y;
      ST_MUL_Y:      state_d = ST_MUL_R;
      ST_MUL_R:      state_d = ST_CMP;
      ST_CMP:        state_d = ST_DIV;
      ST_DIV:        state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:   if (ds_done) state_d = clamp_q ? ST_SQRT : ST_FIN;
      ST_SQRT:       state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT:  if (ds_done) state_d = ST_FIN;
      ST_FIN:        state_d = axis_q ? ST_UPDATE : ST_DIV;
      ST_UPDATE:     state_d = ST_ANGLE;
      ST_ANGLE:      state_d = ST_ANGLE_WAIT;
      ST_ANGLE_WAIT: if (cordic_done) state_d = ST_OUT;
      ST_OUT:        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ds_ctrl.start = 1'b0;
    ds_ctrl.op    = OP_DIV;
    cordic_start  = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_DIV:   ds_ctrl.start = 1'b1;
      ST_SQRT: begin
        ds_ctrl.start = 1'b1;
        ds_ctrl.op    = OP_SQRT;
      end
      ST_ANGLE: cordic_start = 1'b1;
      ST_OUT:   load_out = !out_valid_q || out_ready_i;
      default: begin
        ds_ctrl.start = 1'b0;
      end
    endcase
  end

  // control state, config and per-stick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        radius_q[i] <= 15'h7FFF;
        dz_q[i]     <= '0;
        hdir_q[i]   <= DIR_NONE;
        vdir_q[i]   <= DIR_NONE;
        hcnt_q[i]   <= '0;
        vcnt_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RADIUS0:   radius_q[0] <= cfg_data_i;
          REG_DEADZONE0: dz_q[0]     <= cfg_data_i;
          REG_RADIUS1:   radius_q[1] <= cfg_data_i;
          REG_DEADZONE1: dz_q[1]     <= cfg_data_i;
          default:       ;
        endcase
      end
      if (state_q == ST_CMP) begin
        axis_q <= 1'b0;
      end else if (state_q == ST_FIN) begin
        axis_q <= 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        hdir_q[s_q] <= hd_new;
        vdir_q[s_q] <= vd_new;
        hcnt_q[s_q] <= hcnt_new;
        vcnt_q[s_q] <= vcnt_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s_q   <= stick_select_i;
        x_q   <= raw_x_i;
        y_q   <= raw_y_i;
        r_q   <= r_sel;
        dzs_q <= dz_q[stick_select_i];
      end
      ST_MUL_X: sqx_q <= prod[30:0];
      ST_MUL_Y: sqy_q <= prod[30:0];
      ST_MUL_R: rr_q  <= prod[29:0];
      ST_CMP: begin
        m2_q    <= {1'b0, sqx_q} + {1'b0, sqy_q};
        clamp_q <= ({1'b0, sqx_q} + {1'b0, sqy_q}) > {2'b0, rr_q};
      end
      ST_FIN: begin
        if (axis_q) begin
          py_q <= p_a;
        end else begin
          px_q <= p_a;
        end
      end
      ST_UPDATE: begin
        hd_q <= hd_new;
        vd_q <= vd_new;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      opx_q  <= px_q;
      opy_q  <= py_q;
      oang_q <= cordic_angle;
      ohd_q  <= hd_q;
      ovd_q  <= vd_q;
      if (COUNT_BITS >= 16) begin
        ofx_q <= 16'(hcnt_q[s_q]);
        ofy_q <= 16'(vcnt_q[s_q]);
      end else begin
        ofx_q <= 16'(hcnt_q[s_q]);
        ofy_q <= 16'(vcnt_q[s_q]);
      end
    end
  end

  asc_divsqrt u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ds_ctrl),
    .num_i    (ds_num),
    .den_i    (ds_den),
    .done_o   (ds_done),
    .result_o (ds_result)
  );

  asc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .px_i    (px_q),
    .py_i    (py_q),
    .done_o  (cordic_done),
    .angle_o (cordic_angle)
  );

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = opx_q;
  assign pos_y_o     = opy_q;
  assign angle_deg_o = oang_q;
  assign horiz_dir_o = ohd_q;
  assign vert_dir_o  = ovd_q;
  assign frames_x_o  = ofx_q;
  assign frames_y_o  = ofy_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accepted item lost");
  a_hdir_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && horiz_dir_o == DIR_NONE |-> pos_x_o > -16'sd8192 && pos_x_o < 16'sd8192)
    else $error("horizontal direction mismatch");
  a_vdir_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vert_dir_o == DIR_NONE |-> pos_y_o > -16'sd8192 && pos_y_o < 16'sd8192)
    else $error("vertical direction mismatch");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q || out_ready_i) else $error("output overwritten");
`endif

endmodule
